>>> design/fsa_pkg.sv
// Package: shared types for the fraction sum accumulator.
`default_nettype none
package fsa_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_N1,
    ST_MUL_N2,
    ST_MUL_D,
    ST_GCD,
    ST_DIV_N,
    ST_DIV_D,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

>>> design/fsa_divider.sv
// Iterative restoring divider: one quotient bit per cycle.
`default_nettype none
module fsa_divider #(
  parameter int W = 80
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] den;
  logic [CW-1:0] count;
  logic busy;
  logic [W:0] shifted;
  logic [W:0] diff;

  assign shifted = {remainder, quotient[W-1]};
  assign diff = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(W);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      den <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        remainder <= diff[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end else begin
        remainder <= shifted[W-1:0];
        quotient <= {quotient[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

>>> design/fraction_sum_accumulator_top.sv
// Top level of the fraction sum accumulator.
//
// Input stream s_axis: one transfer carries a signed 16-bit fraction and a
// start flag in tuser. A start transfer loads the fraction as the new sum
// (zero denominator read as one) and clears the sticky overflow flag; any
// other transfer adds the fraction by cross multiplication and reduces the
// result by the Euclidean GCD of the magnitudes.
// Output stream m_axis: one transfer per input with the running numerator,
// denominator and the overflow flag in tuser.
// A load goes straight to the output state. An add runs the multiply
// states MUL_N1, MUL_N2 and MUL_D on a shared SUM_WIDTH x 16 multiplier,
// then the Euclid steps in one shared bit-serial divider of width W
// (W = 2*SUM_WIDTH+16), then two exact divisions by the GCD, then the
// output state. A zero product denominator skips the divider. The Euclid
// step count sets the total time. One item at a time: s_axis_tready is
// low while busy. Reset returns the sum to 1/1, clears the flag and drops
// any result. A stalled receiver holds the result in the output register;
// the next input is taken once that result is transferred.
`default_nettype none
module fraction_sum_accumulator_top #(
  parameter int SUM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // addend_numerator[15:0], addend_denominator[31:16]
  input  wire logic        s_axis_tuser,  // start_sum
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // sum_numerator[31:0], sum_denominator[63:32]
  output logic             m_axis_tuser   // overflow_seen
);
  localparam int S = SUM_WIDTH;
  localparam int W = 2 * S + 16;

  fsa_pkg::state_t state, state_next;
  logic [S-1:0] run_n, run_d;
  logic ovf;
  logic [15:0] in_n_mag, in_d_mag;
  logic in_n_neg, in_d_neg;
  logic [S-1:0] n1, d1;
  logic sn1, sd1;
  logic [15:0] d2, n2;
  logic sn2, sd2;
  logic [W-1:0] t1, acc_a, acc_b, gq, dm_keep;
  logic sn, sd;
  logic [S-1:0] mul_a;
  logic [15:0] mul_b;
  logic [S+15:0] prod;
  logic div_start, div_done;
  logic [W-1:0] div_a, div_b, div_q, div_r;
  logic [15:0] raw_n, raw_d;

  assign raw_n = s_axis_tdata[15:0];
  assign raw_d = s_axis_tdata[31:16];
  assign in_n_neg = raw_n[15];
  assign in_n_mag = in_n_neg ? 16'(-raw_n) : raw_n;
  assign in_d_neg = raw_d[15] && raw_d != 16'h0;
  assign in_d_mag = (raw_d == 16'h0) ? 16'd1 : (in_d_neg ? 16'(-raw_d) : raw_d);

  // shared multiplier
  always_comb begin
    case (state)
      fsa_pkg::ST_MUL_N1: begin mul_a = n1; mul_b = d2; end
      fsa_pkg::ST_MUL_N2: begin mul_a = d1; mul_b = n2; end
      default:            begin mul_a = d1; mul_b = d2; end
    endcase
  end
  assign prod = {16'h0, mul_a} * {{S{1'b0}}, mul_b};

  fsa_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_comb begin
    div_start = 1'b0;
    div_a = acc_a;
    div_b = acc_b;
    case (state)
      fsa_pkg::ST_MUL_D: begin
        // first Euclid step: numerator mod product denominator
        div_start = (prod != '0);
        div_b = W'(prod);
      end
      fsa_pkg::ST_GCD: begin
        div_start = div_done && div_r != '0;
        div_a = acc_b;
        div_b = div_r;
        if (div_done && div_r == '0) begin
          div_start = 1'b1;
          div_a = t1;
          div_b = acc_b;
        end
      end
      fsa_pkg::ST_DIV_N: begin
        div_start = div_done;
        div_a = dm_keep;
        div_b = gq;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      fsa_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tready)
          state_next = s_axis_tuser ? fsa_pkg::ST_OUT : fsa_pkg::ST_MUL_N1;
      fsa_pkg::ST_MUL_N1: state_next = fsa_pkg::ST_MUL_N2;
      fsa_pkg::ST_MUL_N2: state_next = fsa_pkg::ST_MUL_D;
      fsa_pkg::ST_MUL_D:
        state_next = div_start ? fsa_pkg::ST_GCD : fsa_pkg::ST_OUT;
      fsa_pkg::ST_GCD:
        if (div_done && div_r == '0) state_next = fsa_pkg::ST_DIV_N;
      fsa_pkg::ST_DIV_N: if (div_done) state_next = fsa_pkg::ST_DIV_D;
      fsa_pkg::ST_DIV_D: if (div_done) state_next = fsa_pkg::ST_OUT;
      fsa_pkg::ST_OUT: state_next = fsa_pkg::ST_IDLE;
      default: state_next = fsa_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == fsa_pkg::ST_IDLE) && !m_axis_tvalid;

  function automatic logic fits(input logic neg, input logic [W-1:0] m);
    logic [W-1:0] half;
    half = W'(1) << (S - 1);
    fits = neg ? (m <= half) : (m < half);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsa_pkg::ST_IDLE;
      run_n <= S'(1);
      run_d <= S'(1);
      ovf <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        fsa_pkg::ST_IDLE:
          if (s_axis_tvalid && s_axis_tready && s_axis_tuser) begin
            run_n <= in_n_neg ? S'(-{16'h0, in_n_mag}) : S'(in_n_mag);
            run_d <= in_d_neg ? S'(-{16'h0, in_d_mag}) : S'(in_d_mag);
            ovf <= 1'b0;
          end
        fsa_pkg::ST_MUL_D:
          if (!div_start) begin
            // zero denominator: the GCD is the numerator itself, giving
            // +1/0 or -1/0, or 0/0 when the numerator is zero as well
            run_n <= (acc_a == '0) ? '0 : (sn ? '1 : S'(1));
            run_d <= '0;
          end
        fsa_pkg::ST_DIV_D:
          if (div_done) begin
            if (!fits(sn, t1) || !fits(sd, div_q)) ovf <= 1'b1;
            run_n <= sn ? S'(-t1) : S'(t1);
            run_d <= sd ? S'(-div_q) : S'(div_q);
          end
        fsa_pkg::ST_OUT: m_axis_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      fsa_pkg::ST_IDLE: begin
        sn1 <= run_n[S-1];
        sd1 <= run_d[S-1];
        n1 <= run_n[S-1] ? S'(-run_n) : run_n;
        d1 <= run_d[S-1] ? S'(-run_d) : run_d;
        n2 <= in_n_mag;
        sn2 <= in_n_neg;
        d2 <= in_d_mag;
        sd2 <= in_d_neg;
      end
      fsa_pkg::ST_MUL_N1: t1 <= W'(prod);
      fsa_pkg::ST_MUL_N2: begin
        if ((sn1 ^ sd2) == (sd1 ^ sn2)) begin
          acc_a <= t1 + W'(prod); sn <= sn1 ^ sd2;
        end else if (t1 >= W'(prod)) begin
          acc_a <= t1 - W'(prod); sn <= sn1 ^ sd2;
        end else begin
          acc_a <= W'(prod) - t1; sn <= sd1 ^ sn2;
        end
      end
      fsa_pkg::ST_MUL_D: begin
        acc_b <= W'(prod);
        dm_keep <= W'(prod);
        sd <= sd1 ^ sd2;
        t1 <= acc_a;
      end
      fsa_pkg::ST_GCD:
        if (div_done) begin
          if (div_r != '0) begin
            acc_a <= acc_b;
            acc_b <= div_r;
          end else begin
            gq <= acc_b;
            acc_a <= t1;
            acc_b <= acc_b;
          end
        end
      fsa_pkg::ST_DIV_N:
        if (div_done) begin
          t1 <= div_q;
          acc_a <= acc_b;
        end
      default: ;
    endcase
  end

  logic [31:0] out_n, out_d;
  assign out_n = 32'($signed(run_n));
  assign out_d = 32'($signed(run_d));
  assign m_axis_tdata = {out_d, out_n};
  assign m_axis_tuser = ovf;
endmodule
`default_nettype wire
